// ----- hdl/irc_pkg.sv -----
// irc_pkg: widths, constants, digit helpers and controller/datapath
// interface structs for the integer radix converter. No dependencies.
`default_nettype none

package irc_pkg;

   localparam int VALUE_BITS = 63;
   localparam int MAX_DIGITS = 64;
   localparam int ADDR_W     = $clog2(MAX_DIGITS);
   localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
   localparam int BITCNT_W   = $clog2(VALUE_BITS);
   localparam int BASE_W     = 6;
   localparam int REM_W      = BASE_W + 1;
   localparam int CHAR_W     = 7;

   localparam logic [CNT_W-1:0]    RESULT_CAP     = CNT_W'(63);
   localparam logic [CNT_W-1:0]    DIGIT_LIMIT    = CNT_W'(MAX_DIGITS);
   localparam logic [BITCNT_W-1:0] LAST_BIT       = BITCNT_W'(VALUE_BITS - 1);
   localparam logic [BASE_W-1:0]   BASE_MIN       = BASE_W'(2);
   localparam logic [BASE_W-1:0]   BASE_MAX       = BASE_W'(36);
   localparam logic [BASE_W-1:0]   BASE_RESET     = BASE_W'(10);
   localparam logic [BASE_W-1:0]   DECIMAL_LIMIT  = BASE_W'(10);
   localparam logic [CHAR_W-1:0]   ASCII_ZERO     = CHAR_W'(48);
   localparam logic [CHAR_W-1:0]   ASCII_LETTER_A = CHAR_W'(65);

   // controller -> datapath
   typedef struct packed {
      logic start;        // load value, clear digit count
      logic div_step;     // one restoring division bit
      logic store_digit;  // write remainder, restart divider
      logic rd_start;     // point read index at the top digit
      logic rd_next;      // step read index down
      logic load_out;     // capture digit into the output register
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic bit_last;
      logic quotient_zero;
      logic rd_idx_zero;
   } dp_status_type;

   function automatic logic [BASE_W-1:0] effective_base(input logic [BASE_W-1:0] raw);
      logic [BASE_W-1:0] b;
      b = raw;
      if (raw < BASE_MIN) b = BASE_MIN;
      else if (raw > BASE_MAX) b = BASE_MAX;
      return b;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [BASE_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < DECIMAL_LIMIT) c = ASCII_ZERO + CHAR_W'(d);
      else c = ASCII_LETTER_A + CHAR_W'(d - DECIMAL_LIMIT);
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/irc_ram.sv -----
// irc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module irc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- hdl/irc_ctrl.sv -----
// irc_ctrl: sequencing state machine for the radix converter.
// Depends on irc_pkg (command/status structs).
`default_nettype none

module irc_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output irc_pkg::dp_cmd_type         cmd,
   input  wire irc_pkg::dp_status_type status
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIV   = 3'd1;
   localparam logic [2:0] S_STORE = 3'd2;
   localparam logic [2:0] S_SETUP = 3'd3;
   localparam logic [2:0] S_FETCH = 3'd4;
   localparam logic [2:0] S_LOAD  = 3'd5;
   localparam logic [2:0] S_SHOW  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.bit_last) state_in = S_STORE;
         end
         S_STORE: begin
            cmd.store_digit = 1'b1;
            state_in = status.quotient_zero ? S_SETUP : S_DIV;
         end
         S_SETUP: begin
            cmd.rd_start = 1'b1;
            state_in = S_FETCH;
         end
         S_FETCH: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            cmd.load_out = 1'b1;
            state_in = S_SHOW;
         end
         S_SHOW: begin
            if (!rsp_stall) begin
               if (status.rd_idx_zero) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.rd_next = 1'b1;
                  state_in = S_FETCH;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_SHOW);

endmodule

`default_nettype wire

// ----- hdl/irc_dpath.sv -----
// irc_dpath: base register, bit-serial restoring divider, digit counter,
// digit store and output register. Depends on irc_pkg and irc_ram.
`default_nettype none

module irc_dpath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_wr_en,
   input  wire logic [irc_pkg::BASE_W-1:0]           csr_wr_data,
   input  wire logic [irc_pkg::VALUE_BITS-1:0]       value,
   input  wire irc_pkg::dp_cmd_type                  cmd,
   output irc_pkg::dp_status_type                    status,
   output logic      [irc_pkg::CHAR_W-1:0]           out_char,
   output logic                                      out_last
);

   logic [irc_pkg::BASE_W-1:0]     base_ff;
   logic [irc_pkg::VALUE_BITS-1:0] quotient_ff, quotient_in;
   logic [irc_pkg::REM_W-1:0]      rem_ff, rem_in;
   logic [irc_pkg::BITCNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [irc_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [irc_pkg::ADDR_W-1:0]     rd_idx_ff, rd_idx_in;
   logic [irc_pkg::CHAR_W-1:0]     char_ff;
   logic                           last_ff;

   logic [irc_pkg::BASE_W-1:0]     base_eff;
   logic [irc_pkg::REM_W-1:0]      rem_shift;
   logic                           rem_ge;
   logic [irc_pkg::CNT_W-1:0]      count_clip;
   logic                           store_wr;
   logic [irc_pkg::BASE_W-1:0]     rd_digit;

   assign base_eff  = irc_pkg::effective_base(base_ff);
   // one restoring step: bring down the next dividend bit, subtract if it fits
   assign rem_shift = {rem_ff[irc_pkg::REM_W-2:0], quotient_ff[irc_pkg::VALUE_BITS-1]};
   assign rem_ge    = (rem_shift >= {1'b0, base_eff});
   assign count_clip = (count_ff > irc_pkg::RESULT_CAP) ? irc_pkg::RESULT_CAP : count_ff;
   assign store_wr  = cmd.store_digit && (count_ff < irc_pkg::DIGIT_LIMIT);

   always_comb begin
      quotient_in = quotient_ff;
      rem_in      = rem_ff;
      bit_cnt_in  = bit_cnt_ff;
      count_in    = count_ff;
      rd_idx_in   = rd_idx_ff;
      priority if (cmd.start) begin
         quotient_in = value;
         rem_in      = '0;
         bit_cnt_in  = '0;
         count_in    = '0;
      end else if (cmd.div_step) begin
         quotient_in = {quotient_ff[irc_pkg::VALUE_BITS-2:0], rem_ge};
         rem_in      = rem_ge ? (rem_shift - {1'b0, base_eff}) : rem_shift;
         bit_cnt_in  = bit_cnt_ff + 1'b1;
      end else if (cmd.store_digit) begin
         rem_in     = '0;
         bit_cnt_in = '0;
         if (store_wr) count_in = count_ff + 1'b1;
      end else if (cmd.rd_start) begin
         rd_idx_in = irc_pkg::ADDR_W'(count_clip - 1'b1);
      end else if (cmd.rd_next) begin
         rd_idx_in = rd_idx_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= irc_pkg::BASE_RESET;
         count_ff <= '0;
      end else begin
         if (csr_wr_en) base_ff <= csr_wr_data;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quotient_ff <= quotient_in;
      rem_ff      <= rem_in;
      bit_cnt_ff  <= bit_cnt_in;
      rd_idx_ff   <= rd_idx_in;
      if (cmd.load_out) begin
         char_ff <= irc_pkg::digit_to_ascii(rd_digit);
         last_ff <= (rd_idx_ff == '0);
      end
   end

   irc_ram #(
      .WIDTH (irc_pkg::BASE_W),
      .DEPTH (irc_pkg::MAX_DIGITS)
   ) u_digit_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (count_ff[irc_pkg::ADDR_W-1:0]),
      .wr_data (rem_ff[irc_pkg::BASE_W-1:0]),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_digit)
   );

   assign status.bit_last      = (bit_cnt_ff == irc_pkg::LAST_BIT);
   assign status.quotient_zero = (quotient_ff == '0);
   assign status.rd_idx_zero   = (rd_idx_ff == '0);

   assign out_char = char_ff;
   assign out_last = last_ff;

endmodule

`default_nettype wire

// ----- hdl/integer_radix_conversion.sv -----
// integer_radix_conversion: top level of the radix converter.
// Depends on irc_pkg, irc_ctrl, irc_dpath (which holds irc_ram).
`default_nettype none

// Converts one 63-bit unsigned value per transaction into its ASCII digit
// string in the base held in the 6-bit csr register (reset 10; values below
// 2 act as 2, above 36 act as 36). Digits come out one per rsp transaction,
// most significant first, as '0'-'9' then 'A'-'Z'; rsp_is_last marks the
// final, least significant digit. A zero value yields the single digit '0'.
// The block works on one value at a time: req_stall is high from the
// accepted req transaction until the last digit's rsp transaction is taken.
// Each digit costs one pass of a shared bit-serial restoring divider, one
// quotient bit per cycle, then a store of the remainder. Emission reads
// the digit store (registered-read RAM) through fetch, load and show
// states per digit, holding each digit while rsp_stall is high. Write the
// csr only while the block is idle.
module integer_radix_conversion (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // configuration
   input  wire logic                             csr_wr_en,
   input  wire logic [irc_pkg::BASE_W-1:0]       csr_wr_data,
   // input channel
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [irc_pkg::VALUE_BITS-1:0]   req_value,
   // result channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic      [irc_pkg::CHAR_W-1:0]       rsp_digit_char,
   output logic                                  rsp_is_last
);

   irc_pkg::dp_cmd_type    cmd;
   irc_pkg::dp_status_type status;

   // sequencing only; all arithmetic and storage sit in the datapath
   irc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   irc_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .value       (req_value),
      .cmd         (cmd),
      .status      (status),
      .out_char    (rsp_digit_char),
      .out_last    (rsp_is_last)
   );

endmodule

`default_nettype wire

// ----- hdl/irc_checker.sv -----
// irc_checker: port-level assertions for integer_radix_conversion, bound to
// the top level. Depends on irc_pkg for widths and ASCII constants.
`default_nettype none

module irc_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_stall,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire logic [irc_pkg::CHAR_W-1:0]       rsp_digit_char,
   input wire logic                             rsp_is_last
);

   // stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digit_char)
                                 && $stable(rsp_is_last))
      else $error("rsp payload changed under stall");

   // every digit is a legal ASCII digit or capital letter
   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_digit_char >= irc_pkg::ASCII_ZERO)
                     && (rsp_digit_char <= irc_pkg::CHAR_W'(57)))
                 || ((rsp_digit_char >= irc_pkg::ASCII_LETTER_A)
                     && (rsp_digit_char <= irc_pkg::CHAR_W'(90))))
      else $error("illegal digit character");

   // no new value is taken while digits are still being delivered
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted during emission");

   // after the last digit is taken, the block is ready again
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_is_last |=> !rsp_valid && !req_stall)
      else $error("block not idle after last digit");

endmodule

bind integer_radix_conversion irc_checker u_irc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_digit_char (rsp_digit_char),
   .rsp_is_last    (rsp_is_last)
);

`default_nettype wire

// ----- tb/sv/integer_radix_conversion_tb.sv -----
`timescale 1ns / 100ps
// integer_radix_conversion_tb: self-checking testbench for the radix converter.
// Depends on irc_pkg (widths, base limits, ASCII constants) and the
// integer_radix_conversion RTL.
module integer_radix_conversion_tb;

   localparam int HALF_PERIOD   = 2;      // 4 ns clock
   localparam int RESET_CYCLES  = 5;
   localparam int HOLD_CYCLES   = 2000;   // long result hold-off in the fill test
   localparam int IDLE_LIMIT    = 20000;  // watchdog: cycles without any transaction
   localparam int QUIET_GAP     = 4;      // settle time before a csr write
   localparam int SETTLE_CYCLES = 200;    // final wait for stray digits
   localparam int PHASE_VALUES  = 40;     // values per random idling phase

   // One expected digit transaction.
   typedef struct packed {
      logic [irc_pkg::CHAR_W-1:0] ch;
      logic                       last;
   } digit_exp_type;

   // All block inputs start at known values.
   logic                           clock       = 1'b0;
   logic                           reset       = 1'b1;
   logic                           csr_wr_en   = 1'b0;
   logic [irc_pkg::BASE_W-1:0]     csr_wr_data = irc_pkg::BASE_RESET;
   logic                           req_valid   = 1'b0;
   logic [irc_pkg::VALUE_BITS-1:0] req_value   = '0;
   logic                           rsp_stall   = 1'b0;

   logic                           req_stall;
   logic                           rsp_valid;
   logic [irc_pkg::CHAR_W-1:0]     rsp_digit_char;
   logic                           rsp_is_last;

   // Shadow of the base register as the block holds it (raw, unclamped).
   logic [irc_pkg::BASE_W-1:0]     base_raw = irc_pkg::BASE_RESET;
   digit_exp_type                  pending_digits[$];

   int snd_idle_pct  = 0;   // percent of cycles the sender withholds a value
   int rcv_stall_pct = 0;   // percent of cycles the receiver stalls a digit
   logic hold_on     = 1'b0;

   int error_count    = 0;
   int values_sent    = 0;
   int digits_checked = 0;
   int bases_written  = 0;
   int quiet_cycles   = 0;

   always #(HALF_PERIOD) clock = ~clock;

   integer_radix_conversion dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_is_last    (rsp_is_last)
   );

   // ---------------------------------------------------------------------
   // Digit predictor: repeated division by the clamped base, remainders
   // kept least significant first, then queued most significant first as
   // ASCII with the final digit flagged. Zero gives the single digit '0'.
   // ---------------------------------------------------------------------
   function automatic void expand_digits(input logic [irc_pkg::VALUE_BITS-1:0] value);
      logic [irc_pkg::BASE_W-1:0]     radix;
      logic [irc_pkg::VALUE_BITS-1:0] quotient;
      logic [irc_pkg::BASE_W-1:0]     rems [irc_pkg::MAX_DIGITS];
      logic [irc_pkg::BASE_W-1:0]     r;
      digit_exp_type                  d;
      int                             n;
      int                             ndig;
      int                             k;
      radix = base_raw;
      if (radix < irc_pkg::BASE_MIN) radix = irc_pkg::BASE_MIN;
      else if (radix > irc_pkg::BASE_MAX) radix = irc_pkg::BASE_MAX;
      quotient = value;
      n = 0;
      do begin
         r = irc_pkg::BASE_W'(quotient % irc_pkg::VALUE_BITS'(radix));
         quotient = quotient / irc_pkg::VALUE_BITS'(radix);
         if (n < irc_pkg::MAX_DIGITS) begin
            rems[n] = r;
            n++;
         end
      end while (quotient != 0);
      // only the least significant digits that fit the result cap come out
      ndig = (n > int'(irc_pkg::RESULT_CAP)) ? int'(irc_pkg::RESULT_CAP) : n;
      for (k = 0; k < ndig; k++) begin
         r = rems[ndig - 1 - k];
         if (r < irc_pkg::DECIMAL_LIMIT)
            d.ch = irc_pkg::ASCII_ZERO + irc_pkg::CHAR_W'(r);
         else
            d.ch = irc_pkg::ASCII_LETTER_A + irc_pkg::CHAR_W'(r - irc_pkg::DECIMAL_LIMIT);
         d.last = (k == ndig - 1);
         pending_digits.push_back(d);
      end
   endfunction

   // Random value of random magnitude, so short and long digit strings mix;
   // full-width values keep bit 62 toggling.
   function automatic logic [irc_pkg::VALUE_BITS-1:0] random_value();
      logic [63:0] wide;
      int          nbits;
      wide  = {$urandom(), $urandom()};
      nbits = $urandom_range(1, irc_pkg::VALUE_BITS);
      if ($urandom_range(0, 15) == 0) return '0;
      return wide[irc_pkg::VALUE_BITS-1:0] >> (irc_pkg::VALUE_BITS - nbits);
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   // Offer one value; valid stays high after acceptance so back-to-back
   // transactions need no second assignment in the same step.
   task automatic offer_value(input logic [irc_pkg::VALUE_BITS-1:0] value);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expand_digits(value);
      values_sent++;
   endtask

   // Sender pauses until every queued digit has been taken.
   task automatic wait_for_digits();
      req_valid <= 1'b0;
      while (pending_digits.size() != 0) @(posedge clock);
      repeat (QUIET_GAP) @(posedge clock);
   endtask

   // csr writes only with the block idle.
   task automatic write_base(input logic [irc_pkg::BASE_W-1:0] b);
      wait_for_digits();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= b;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      base_raw = b;
      bases_written++;
   endtask

   task automatic set_idling(input int snd_pct, input int rcv_pct);
      snd_idle_pct = snd_pct;
      rcv_stall_pct <= rcv_pct;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset base (decimal): zero, single digits, carry into two digits,
   // and the largest value.
   task automatic test_decimal_defaults();
      offer_value('0);
      offer_value(irc_pkg::VALUE_BITS'(1));
      offer_value(irc_pkg::VALUE_BITS'(9));
      offer_value(irc_pkg::VALUE_BITS'(10));
      offer_value('1);
   endtask

   // Base extremes and clamping: base 2 with the full 63-digit string,
   // base 36 letters up to 'Z', raw 0 and 1 acting as 2, 37 and 63 acting
   // as 36, hex for the letters A-E.
   task automatic test_base_limits();
      write_base(irc_pkg::BASE_W'(2));
      offer_value('0);
      offer_value(irc_pkg::VALUE_BITS'(1));
      offer_value('1);
      write_base(irc_pkg::BASE_W'(36));
      offer_value(irc_pkg::VALUE_BITS'(35));
      offer_value(irc_pkg::VALUE_BITS'(36));
      offer_value(irc_pkg::VALUE_BITS'(1295));
      offer_value('1);
      write_base(irc_pkg::BASE_W'(0));
      offer_value(irc_pkg::VALUE_BITS'(5));
      write_base(irc_pkg::BASE_W'(1));
      offer_value(irc_pkg::VALUE_BITS'(6));
      write_base(irc_pkg::BASE_W'(37));
      offer_value(irc_pkg::VALUE_BITS'(71));
      write_base(irc_pkg::BASE_W'(63));
      offer_value('1);
      write_base(irc_pkg::BASE_W'(16));
      offer_value(63'h7EDC_BA98_7654_3210);
   endtask

   // Random values under four random base settings per idling mix.
   task automatic test_random_conversions(input int snd_pct, input int rcv_pct);
      int seg;
      int i;
      set_idling(snd_pct, rcv_pct);
      for (seg = 0; seg < 4; seg++) begin
         write_base(irc_pkg::BASE_W'($urandom_range(0, 63)));
         for (i = 0; i < PHASE_VALUES / 4; i++) offer_value(random_value());
      end
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering,
   // so the block fills and stalls its input; then the digits drain.
   task automatic test_stall_fill();
      set_idling(0, 0);
      write_base(irc_pkg::BASE_W'(10));
      fork
         begin
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_on <= 1'b0;
         end
         begin
            offer_value('1);
            offer_value(random_value());
            offer_value(random_value());
         end
      join
      wait_for_digits();
   endtask

   // ---------------------------------------------------------------------
   // Result side: random stalls plus the hold-off window.
   // ---------------------------------------------------------------------
   always @(posedge clock)
      rsp_stall <= hold_on || ($urandom_range(0, 99) < rcv_stall_pct);

   // Every digit transaction is checked against the oldest expectation.
   always @(posedge clock) begin : digit_check
      digit_exp_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_digits.size() == 0) begin
            report_mismatch($sformatf("unexpected digit 0x%02h last %b",
                                      rsp_digit_char, rsp_is_last));
         end else begin
            want = pending_digits.pop_front();
            digits_checked++;
            if (rsp_digit_char !== want.ch)
               report_mismatch($sformatf("digit_char got 0x%02h want 0x%02h (value #%0d)",
                                         rsp_digit_char, want.ch, values_sent));
            if (rsp_is_last !== want.last)
               report_mismatch($sformatf("is_last got %b want %b (value #%0d)",
                                         rsp_is_last, want.last, values_sent));
         end
      end
   end

   // Watchdog: too long without any transaction on either channel.
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d digits outstanding",
                  IDLE_LIMIT, pending_digits.size());
         $display("integer_radix_conversion verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence: reset once, directed tests, three idling mixes, fill test.
   // ---------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      set_idling(6, 88);
      test_decimal_defaults();
      test_base_limits();
      test_random_conversions(6, 88);
      test_random_conversions(88, 6);
      test_random_conversions(0, 0);
      test_stall_fill();
      wait_for_digits();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_digits.size() != 0)
         report_mismatch($sformatf("%0d digits never arrived", pending_digits.size()));
      $display("covered %0d values and %0d digits over %0d base writes (clamped 0/1/37/63",
               values_sent, digits_checked, bases_written);
      $display("  included), three idle mixes and a %0d-cycle result hold-off; %0d errors",
               HOLD_CYCLES, error_count);
      if (error_count == 0) begin
         $display("integer_radix_conversion verification clean");
      end else begin
         $display("integer_radix_conversion verification failed");
      end
      $finish;
   end

endmodule
